### design/flcu_pkg.sv
// package for the fixed-length code unpacker: payload structs, command and
// status codes, fsm states and reset values. no dependencies.
`default_nettype none

package flcu_pkg;

    localparam int MAX_CODE_LENGTH_DEF = 8;

    localparam logic [3:0] CODE_LENGTH_RESET = 4'd8;
    localparam logic [2:0] PAD_BITS_RESET    = 3'd0;

    // commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // result status
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN  = 2'd1;
    localparam logic [1:0] STAT_TRAILING = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CODE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_PAD_BITS    = 2'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] entry_index;
        logic [7:0] entry_symbol;
        logic       entry_valid;
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic [1:0] status;
        logic       run_end;
    } out_item_t;

    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic [7:0] symbol;
        logic       valid;
    } tbl_wr_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] symbol;
    } tbl_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_LOOKUP,
        S_TRAIL
    } state_t;

endpackage

`default_nettype wire

### design/flcu_table.sv
// symbol table: one memory of symbols plus a valid flop per entry,
// one write and one registered read port. depends on flcu_pkg.
`default_nettype none

module flcu_table
    import flcu_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tbl_wr_t                    tbl_wr,
    input  wire logic                       rd_en,
    input  wire logic [MAX_CODE_LENGTH-1:0] rd_addr,
    output tbl_entry_t                      rd_entry
);

    localparam int AW    = MAX_CODE_LENGTH;
    localparam int DEPTH = 1 << AW;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    tbl_entry_t       rd_entry_reg;
    logic             wr_hit;
    logic [AW-1:0]    wr_addr;

    // indexes beyond the longest code can never be looked up
    assign wr_hit  = tbl_wr.en && ({1'b0, tbl_wr.index} < 9'(DEPTH));
    assign wr_addr = tbl_wr.index[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_hit)
        begin
            valid_reg[wr_addr] <= tbl_wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[wr_addr] <= tbl_wr.symbol;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg.valid  <= valid_reg[rd_addr];
            rd_entry_reg.symbol <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

### design/flcu_unpack.sv
// bit-serial unpacker: shifts a byte into the partial code one bit per cycle,
// pausing to look up each code and build its result. depends on flcu_pkg.
`default_nettype none

module flcu_unpack
    import flcu_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire in_item_t                   in_data,
    input  wire logic [3:0]                 code_length,
    input  wire logic [2:0]                 pad_bits,
    output tbl_wr_t                         tbl_wr,
    output logic                            rd_en,
    output logic [MAX_CODE_LENGTH-1:0]      rd_addr,
    input  wire tbl_entry_t                 rd_entry,
    input  wire logic                       res_free,
    output logic                            res_load,
    output out_item_t                       res_data
);

    localparam logic [3:0] MAX_LEN = 4'(MAX_CODE_LENGTH);

    state_t     state_reg, state_next;
    logic [7:0] shift_reg, shift_next;
    logic [3:0] left_reg, left_next;
    logic       final_reg, final_next;
    logic [7:0] partial_reg, partial_next;
    logic [2:0] count_reg, count_next;
    logic       halt_reg, halt_next;
    logic       last_reg, last_next;

    logic [3:0] len;
    logic [7:0] mask;
    logic [7:0] acc;
    logic [7:0] idx;
    logic [3:0] cnt;
    logic [3:0] left_after;
    logic       code_done;
    logic       code_last;

    always_comb
    begin
        if (code_length == 4'd0)
            len = 4'd1;
        else if (code_length > MAX_LEN)
            len = MAX_LEN;
        else
            len = code_length;
    end

    assign mask       = 8'hFF >> (4'd8 - len);
    assign acc        = {partial_reg[6:0], shift_reg[7]};
    assign idx        = acc & mask;
    assign cnt        = {1'b0, count_reg} + 4'd1;
    assign code_done  = cnt >= len;
    assign left_after = left_reg - 4'd1;
    // no further code and no trailing error after this one
    assign code_last  = (left_after < len) && !(final_reg && left_after != 4'd0);
    assign rd_addr    = idx[MAX_CODE_LENGTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            partial_reg <= '0;
            count_reg   <= '0;
            halt_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            partial_reg <= partial_next;
            count_reg   <= count_next;
            halt_reg    <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        left_reg  <= left_next;
        final_reg <= final_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        final_next   = final_reg;
        partial_next = partial_reg;
        count_next   = count_reg;
        halt_next    = halt_reg;
        last_next    = last_reg;
        in_ready     = 1'b0;
        rd_en        = 1'b0;
        res_load     = 1'b0;
        res_data     = '0;
        tbl_wr.en     = 1'b0;
        tbl_wr.index  = in_data.entry_index;
        tbl_wr.symbol = in_data.entry_symbol;
        tbl_wr.valid  = in_data.entry_valid;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_data.command)
                        CMD_LOAD:
                        begin
                            tbl_wr.en = 1'b1;
                        end
                        CMD_START:
                        begin
                            partial_next = '0;
                            count_next   = '0;
                            halt_next    = 1'b0;
                        end
                        CMD_DATA:
                        begin
                            if (!halt_reg)
                            begin
                                shift_next = in_data.data_byte;
                                final_next = in_data.final_byte;
                                if (in_data.final_byte && len != 4'd8)
                                    left_next = 4'd8 - {1'b0, pad_bits};
                                else
                                    left_next = 4'd8;
                                state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (left_reg == 4'd0)
                begin
                    if (final_reg && count_reg != 3'd0)
                        state_next = S_TRAIL;
                    else
                        state_next = S_IDLE;
                end
                else
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    left_next  = left_after;
                    if (code_done)
                    begin
                        rd_en        = 1'b1;
                        partial_next = '0;
                        count_next   = '0;
                        last_next    = code_last;
                        state_next   = S_LOOKUP;
                    end
                    else
                    begin
                        partial_next = acc;
                        count_next   = cnt[2:0];
                    end
                end
            end
            S_LOOKUP:
            begin
                if (res_free)
                begin
                    res_load = 1'b1;
                    if (rd_entry.valid)
                    begin
                        res_data.symbol  = rd_entry.symbol;
                        res_data.status  = STAT_OK;
                        res_data.run_end = last_reg;
                        state_next       = S_SHIFT;
                    end
                    else
                    begin
                        // unknown code drops the rest of the byte
                        res_data.status  = STAT_UNKNOWN;
                        res_data.run_end = 1'b1;
                        halt_next        = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
            end
            S_TRAIL:
            begin
                if (res_free)
                begin
                    res_load         = 1'b1;
                    res_data.status  = STAT_TRAILING;
                    res_data.run_end = 1'b1;
                    halt_next        = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/flcu_outbuf.sv
// output register for results, decouples the unpacker from the consumer.
// depends on flcu_pkg.
`default_nettype none

module flcu_outbuf
    import flcu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      res_load,
    input  wire out_item_t res_data,
    output logic           res_free,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      valid_reg;
    out_item_t data_reg;

    assign res_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res_data;
        end
    end

endmodule

`default_nettype wire

### design/fixed_length_code_unpacker.sv
// top level of the fixed-length code unpacker: config registers, unpacker,
// symbol table and output register. depends on flcu_pkg and the flcu modules.
//
//   channel   handshake              payload
//   -------   --------------------   -------------------------------------
//   in        in_valid / in_ready    in_data (in_item_t)
//   out       out_valid / out_ready  out_data (out_item_t)
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// load, start and ignored requests are taken in the idle state. a data byte
// is accepted in the idle state, then shifted one code bit per cycle, with a
// registered table read in the lookup state per completed code, an end step
// in the shift state, and the trailing state for a trailing error.
// a full output register holds the unpacker in its lookup or trailing state.
// no clearing pass after reset: table entries carry valid flops.
`default_nettype none

module fixed_length_code_unpacker
    import flcu_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [3:0] cfg_data
);

    logic [3:0] code_length_reg;
    logic [2:0] pad_bits_reg;

    tbl_wr_t                    tbl_wr;
    logic                       rd_en;
    logic [MAX_CODE_LENGTH-1:0] rd_addr;
    tbl_entry_t                 rd_entry;
    logic                       res_free;
    logic                       res_load;
    out_item_t                  res_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= CODE_LENGTH_RESET;
            pad_bits_reg    <= PAD_BITS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CODE_LENGTH: code_length_reg <= cfg_data;
                CFG_PAD_BITS:    pad_bits_reg    <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    flcu_unpack #(
        .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
    ) u_unpack (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .code_length(code_length_reg),
        .pad_bits   (pad_bits_reg),
        .tbl_wr     (tbl_wr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_entry   (rd_entry),
        .res_free   (res_free),
        .res_load   (res_load),
        .res_data   (res_data)
    );

    flcu_table #(
        .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .tbl_wr  (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_entry(rd_entry)
    );

    flcu_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res_data (res_data),
        .res_free (res_free),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> res_free)
        else $error("result loaded into a full output register");

    // no table lookup while taking a new request
    a_no_lookup_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rd_en)
        else $error("table read while idle");

    // error results end the run and carry no symbol
    a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != STAT_OK) |->
            (out_data.run_end && out_data.symbol == 8'd0))
        else $error("error result without run end or with a symbol");

endmodule

`default_nettype wire

### tb/tb_fixed_length_code_unpacker.sv
// self-checking testbench for the fixed-length code unpacker: directed and random
// requests with a bit-serial decode predictor and an in-order result check.
// depends on flcu_pkg and fixed_length_code_unpacker.
`timescale 1ns / 100ps

module tb_fixed_length_code_unpacker;
    import flcu_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_BYTES    = 130;
    localparam int TABLE_FILL      = 64;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [3:0] cfg_data = '0;

    // decode predictor state
    tbl_entry_t symbol_copy [256];
    logic [7:0] shift_code;
    int         shift_count;
    bit         halted;
    logic [3:0] len_reg;
    logic [2:0] pad_reg;
    out_item_t  awaited_symbols [$];

    int errors = 0;
    int data_bytes_sent = 0;
    int src_gap_pct = 0;
    int sink_gap_pct = 0;
    int sink_gap = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stalled_cycles = 0;
    out_item_t want;

    fixed_length_code_unpacker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t make_item(logic [1:0] cmd);
        in_item_t it;
        it.command      = cmd;
        it.entry_index  = 8'($urandom);
        it.entry_symbol = 8'($urandom);
        it.entry_valid  = 1'($urandom);
        it.data_byte    = 8'($urandom);
        it.final_byte   = 1'($urandom);
        return it;
    endfunction

    // expected results of one accepted request, appended to awaited_symbols
    function automatic void decode_request(in_item_t it);
        int         len;
        int         nbits;
        int         cnt;
        logic [7:0] acc;
        logic [7:0] mask;
        tbl_entry_t entry;
        out_item_t  res;
        out_item_t  found [$];
        bit         failed;
        failed = 1'b0;
        case (it.command)
            CMD_LOAD:
            begin
                entry.valid  = it.entry_valid;
                entry.symbol = it.entry_symbol;
                symbol_copy[it.entry_index] = entry;
            end
            CMD_START:
            begin
                shift_code  = '0;
                shift_count = 0;
                halted      = 1'b0;
            end
            CMD_DATA:
            begin
                if (!halted)
                begin
                    if (len_reg == 4'd0)
                        len = 1;
                    else if (int'(len_reg) > MAX_CODE_LENGTH_DEF)
                        len = MAX_CODE_LENGTH_DEF;
                    else
                        len = int'(len_reg);
                    mask  = (len >= 8) ? 8'hFF : 8'((1 << len) - 1);
                    nbits = (it.final_byte && len != 8) ? 8 - int'(pad_reg) : 8;
                    for (int i = 0; i < nbits; i++)
                    begin
                        acc = {shift_code[6:0], it.data_byte[7 - i]};
                        cnt = shift_count + 1;
                        if (cnt >= len)
                        begin
                            entry       = symbol_copy[acc & mask];
                            shift_code  = '0;
                            shift_count = 0;
                            res.run_end = 1'b0;
                            if (!entry.valid)
                            begin
                                res.symbol = 8'h00;
                                res.status = STAT_UNKNOWN;
                                found.push_back(res);
                                halted = 1'b1;
                                failed = 1'b1;
                                break;
                            end
                            res.symbol = entry.symbol;
                            res.status = STAT_OK;
                            found.push_back(res);
                        end
                        else
                        begin
                            shift_code  = acc;
                            shift_count = cnt;
                        end
                    end
                    // code left incomplete at the end of the stream
                    if (it.final_byte && !failed && shift_count != 0)
                    begin
                        res.symbol  = 8'h00;
                        res.status  = STAT_TRAILING;
                        res.run_end = 1'b0;
                        found.push_back(res);
                        halted = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (found.size() > 0)
            found[found.size() - 1].run_end = 1'b1;
        foreach (found[k])
            awaited_symbols.push_back(found[k]);
    endfunction

    task automatic send_req(input in_item_t item);
        int gap;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_ready !== 1'b1);
        decode_request(item);
        if (item.command == CMD_DATA)
            data_bytes_sent++;
    endtask

    task automatic load_entry(input logic [7:0] idx, input logic [7:0] sym, input logic vld);
        in_item_t it;
        it              = make_item(CMD_LOAD);
        it.entry_index  = idx;
        it.entry_symbol = sym;
        it.entry_valid  = vld;
        send_req(it);
    endtask

    task automatic send_data(input logic [7:0] value, input logic last);
        in_item_t it;
        it            = make_item(CMD_DATA);
        it.data_byte  = value;
        it.final_byte = last;
        send_req(it);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == CFG_CODE_LENGTH)
            len_reg = value;
        else if (idx == CFG_PAD_BITS)
            pad_reg = value[2:0];
    endtask

    // only called while idle: every result in and the settle time spent
    task automatic set_config(input logic [3:0] len, input logic [3:0] pad, input bit unused);
        write_reg(CFG_CODE_LENGTH, len);
        write_reg(CFG_PAD_BITS, pad);
        if (unused)
            write_reg(CFG_UNUSED, 4'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (awaited_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_basic_lookup();
        load_entry(8'h00, 8'hFF, 1'b1);
        load_entry(8'hFF, 8'h00, 1'b1);
        load_entry(8'hA5, 8'h5A, 1'b0);
        send_req(make_item(CMD_START));
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b1);
        send_req(make_item(CMD_UNUSED));
        send_req(make_item(CMD_START));
        send_data(8'hA5, 1'b0);
        // halted after the unknown code
        send_data(8'h00, 1'b0);
        send_req(make_item(CMD_START));
        send_data(8'h00, 1'b1);
        drain_and_settle();
    endtask

    task automatic test_trailing_bits();
        set_config(4'd2, 4'd7, 1'b0);
        for (int i = 0; i < 4; i++)
            load_entry(8'(i), 8'($urandom), 1'b1);
        send_req(make_item(CMD_START));
        send_data(8'h1B, 1'b0);
        // one bit left after padding, never completes a code
        send_data(8'hC0, 1'b1);
        send_data(8'h00, 1'b1);
        drain_and_settle();
    endtask

    task automatic test_length_edges();
        set_config(4'd0, 4'd0, 1'b1);
        send_req(make_item(CMD_START));
        send_data(8'h96, 1'b1);
        drain_and_settle();
        // length clamps to eight, so padding does not apply
        set_config(4'd15, 4'd15, 1'b0);
        send_req(make_item(CMD_START));
        send_data(8'h02, 1'b1);
        drain_and_settle();
    endtask

    task automatic test_length_change();
        set_config(4'd5, 4'd0, 1'b0);
        send_req(make_item(CMD_START));
        send_data(8'h0F, 1'b0);
        drain_and_settle();
        // three bits pending, the next bit completes a two-bit code
        set_config(4'd2, 4'd8, 1'b0);
        send_data(8'h00, 1'b0);
        drain_and_settle();
    endtask

    task automatic test_output_stall();
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        set_config(4'd1, 4'd0, 1'b0);
        load_entry(8'h00, 8'h3C, 1'b1);
        load_entry(8'h01, 8'hC3, 1'b1);
        send_req(make_item(CMD_START));
        hold_reqs <= hold_reqs + 1;
        repeat (6) send_data(8'($urandom), 1'b0);
        send_data(8'($urandom), 1'b1);
        drain_and_settle();
    endtask

    task automatic run_stream();
        int       nbytes;
        in_item_t it;
        if ($urandom_range(0, 99) < 85)
            send_req(make_item(CMD_START));
        nbytes = $urandom_range(1, 6);
        for (int b = 0; b < nbytes; b++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_req(make_item(2'($urandom_range(0, 3))));
            it            = make_item(CMD_DATA);
            it.final_byte = (b == nbytes - 1) && ($urandom_range(0, 99) < 90);
            send_req(it);
        end
        if ($urandom_range(0, 99) < 10)
        begin
            it             = make_item(CMD_LOAD);
            it.entry_valid = ($urandom_range(0, 99) < 85);
            send_req(it);
        end
    endtask

    task automatic test_random_streams();
        int         phase;
        logic [3:0] len_val;
        in_item_t   it;
        // short codes find a filled table, long ones also hit empty entries
        for (int i = 0; i < TABLE_FILL; i++)
        begin
            it             = make_item(CMD_LOAD);
            it.entry_index = 8'(i);
            it.entry_valid = (i < 4) || ($urandom_range(0, 15) != 0);
            send_req(it);
        end
        phase = 0;
        data_bytes_sent = 0;
        while (data_bytes_sent < RANDOM_BYTES)
        begin
            drain_and_settle();
            case (phase)
                0: set_config(4'd1, 4'd0, 1'b0);
                1: set_config(4'd8, 4'd7, 1'b0);
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                        len_val = 4'($urandom_range(0, 15));
                    else
                        len_val = 4'($urandom_range(1, 8));
                    set_config(len_val, 4'($urandom), $urandom_range(0, 3) == 0);
                end
            endcase
            if (phase == 2)
            begin
                src_gap_pct  = 0;
                sink_gap_pct = 0;
            end
            else
            begin
                src_gap_pct  = $urandom_range(0, 2) * 30;
                sink_gap_pct = $urandom_range(0, 2) * 30;
            end
            repeat (8) run_stream();
            phase++;
        end
        drain_and_settle();
    endtask

    // receiver: random stalls, plus a long hold-off on request from the test
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap  <= 0;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap <= sink_gap - 1;
        end
        else if ($urandom_range(0, 99) < sink_gap_pct)
        begin
            out_ready <= 1'b0;
            sink_gap  <= pick_gap() - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_symbols.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = awaited_symbols.pop_front();
                if (out_data.symbol !== want.symbol)
                begin
                    $display("%0t: symbol expected %h actual %h",
                             $time, want.symbol, out_data.symbol);
                    errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_data.status);
                    errors++;
                end
                if (out_data.run_end !== want.run_end)
                begin
                    $display("%0t: run_end expected %b actual %b",
                             $time, want.run_end, out_data.run_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            stalled_cycles <= 0;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress, %0d results outstanding", $time,
                         awaited_symbols.size());
                $display("fixed_length_code_unpacker: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 256; i++)
            symbol_copy[i] = '0;
        shift_code  = '0;
        shift_count = 0;
        halted      = 1'b0;
        len_reg     = CODE_LENGTH_RESET;
        pad_reg     = PAD_BITS_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_lookup();
        test_trailing_bits();
        test_length_edges();
        test_length_change();
        test_output_stall();
        test_random_streams();

        drain_and_settle();
        if (errors == 0 && awaited_symbols.size() == 0)
            $display("fixed_length_code_unpacker: match");
        else
            $display("fixed_length_code_unpacker: mismatch");
        $finish;
    end

endmodule
